// ===== hdl/dsss_pkg.sv =====
`default_nettype none

package dsss_pkg;

  // Opcode of one input transaction.
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_STOP   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  // Status code returned with every result.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_CFG    = 3'd1,
    ST_NOT_ACTIVE = 3'd2,
    ST_SAME_STATE = 3'd3,
    ST_BAD_STREAM = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_AMPLITUDE    = 2'd1,
    REG_BLOCK_LEN    = 2'd2,
    REG_CONFIGURED   = 2'd3
  } reg_e;

  // Control part of a classified transaction, carried through the queue.
  typedef struct packed {
    logic    sample_valid;
    logic    block_last;
    status_e status;
  } ctl_t;

  localparam int unsigned CtlW        = $bits(ctl_t);
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned StreamCount = 1;
  localparam int unsigned SineW       = 15;
  localparam logic [63:0] Q30One      = 64'd1 << 30;
  localparam logic [63:0] HalfPiQ30   = 64'd1686629713;

  // One quarter-wave entry in Q1.15, sin((pi/2) * idx / 2^addr_bits), built from
  // a nested Taylor series in Q30 fixed point. Evaluated at elaboration only.
  function automatic logic [SineW-1:0] sine_entry(input int unsigned idx,
                                                  input int unsigned addr_bits);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] e;
    t  = (HalfPiQ30 * 64'(idx)) >> addr_bits;
    t2 = (t * t) >> 30;
    r  = Q30One;
    r  = Q30One - (((t2 * r) >> 30) / 64'd110);
    r  = Q30One - (((t2 * r) >> 30) / 64'd72);
    r  = Q30One - (((t2 * r) >> 30) / 64'd42);
    r  = Q30One - (((t2 * r) >> 30) / 64'd20);
    r  = Q30One - (((t2 * r) >> 30) / 64'd6);
    s  = (t * r) >> 30;
    e  = (s * 64'd32767 + (Q30One >> 1)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return e[SineW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dds_sine_sample_source.sv =====
// Sine sample source built as a direct digital synthesizer. Each input
// transaction carries an opcode (start, stop or sample request) and a stream
// number, and each one produces exactly one output transaction holding a
// status and, for a good sample request, a 16-bit sample equal to
// sin(phase) times the configured amplitude, truncated toward zero, plus a
// flag on the last sample of each block. The block takes one transaction
// per clock cycle, back to back, while the output side is not stalling;
// a result passes through the two-entry queue behind the decoder and then
// the registered sine table read, with the multiply landing in the output
// register. The phase accumulator and block counter are updated in the
// decoder at acceptance, so a stalled output only fills the queue and then
// drops in_ready_o. Configuration registers are written through a plain
// write port and should only be changed while no transaction is in flight.
`default_nettype none

module dds_sine_sample_source #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  // Input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [7:0]         stream_id_i,
  // Output channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      pcm_sample_o,
  output logic                    sample_valid_o,
  output logic                    block_last_o,
  output logic [2:0]              status_o
);
  import dsss_pkg::*;

  localparam int unsigned AddrW = TABLE_ADDR_BITS + 1;
  localparam int unsigned EntW  = CtlW + 1 + AddrW;

  // Configuration registers.
  logic [31:0]        phase_step_q;
  logic signed [15:0] amplitude_q;
  logic [15:0]        block_len_q;
  logic               configured_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      amplitude_q  <= 16'sd16384;
      block_len_q  <= 16'd1;
      configured_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_PHASE_STEP: phase_step_q <= cfg_wdata_i;
        REG_AMPLITUDE:  amplitude_q  <= $signed(cfg_wdata_i[15:0]);
        REG_BLOCK_LEN:  block_len_q  <= cfg_wdata_i[15:0];
        REG_CONFIGURED: configured_q <= cfg_wdata_i[0];
        default:        configured_q <= configured_q;
      endcase
    end
  end

  // Front end: decode, check and update the generator state.
  logic             q_full;
  logic             q_push;
  ctl_t             f_ctl;
  logic             f_neg;
  logic [AddrW-1:0] f_addr;

  dsss_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .stream_id_i  (stream_id_i),
    .phase_step_i (phase_step_q),
    .block_len_i  (block_len_q),
    .configured_i (configured_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_ctl_o      (f_ctl),
    .q_neg_o      (f_neg),
    .q_addr_o     (f_addr)
  );

  // Queue between the decoder and the sample pipeline.
  logic [EntW-1:0] q_wdata;
  logic [EntW-1:0] q_rdata;
  logic            q_pop;
  logic            q_empty;

  assign q_wdata = {f_ctl, f_neg, f_addr};

  dsss_queue #(
    .WIDTH (EntW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // Back end: sine table read, amplitude scaling and output register.
  ctl_t             b_ctl;
  logic             b_neg;
  logic [AddrW-1:0] b_addr;

  assign {b_ctl, b_neg, b_addr} = q_rdata;

  dsss_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .q_ctl_i        (b_ctl),
    .q_neg_i        (b_neg),
    .q_addr_i       (b_addr),
    .amplitude_i    (amplitude_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pcm_sample_o   (pcm_sample_o),
    .sample_valid_o (sample_valid_o),
    .block_last_o   (block_last_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

// ===== hdl/dsss_front.sv =====
`default_nettype none

module dsss_front #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 opcode_i,
  input  wire logic [7:0]                 stream_id_i,
  // Configuration
  input  wire logic [31:0]                phase_step_i,
  input  wire logic [15:0]                block_len_i,
  input  wire logic                       configured_i,
  // Queue write side
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output dsss_pkg::ctl_t                  q_ctl_o,
  output logic                            q_neg_o,
  output logic [TABLE_ADDR_BITS:0]        q_addr_o
);
  import dsss_pkg::*;

  localparam int unsigned AddrW = TABLE_ADDR_BITS + 1;

  logic                  running_q, running_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [15:0]           blkpos_q, blkpos_d;

  logic                  accept;
  logic [PHASE_BITS-1:0] step;
  logic [1:0]            quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [15:0]           blk_len;
  logic [16:0]           blk_next;
  logic                  is_last;
  ctl_t                  ctl;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;

  assign step = PHASE_BITS'(phase_step_i);
  assign quad = phase_q[PHASE_BITS-1 -: 2];
  assign idx  = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];

  // A zero block length behaves as one sample per block.
  assign blk_len  = (block_len_i == 16'd0) ? 16'd1 : block_len_i;
  assign blk_next = {1'b0, blkpos_q} + 17'd1;
  assign is_last  = (blk_next >= {1'b0, blk_len});

  always_comb begin
    running_d = running_q;
    phase_d   = phase_q;
    blkpos_d  = blkpos_q;
    ctl       = '{sample_valid: 1'b0, block_last: 1'b0, status: ST_OK};
    if (!configured_i) begin
      ctl.status = ST_NOT_CFG;
    end else begin
      unique case (op_e'(opcode_i))
        OP_START: begin
          if (running_q) begin
            ctl.status = ST_SAME_STATE;
          end else begin
            running_d = 1'b1;
            phase_d   = '0;
            blkpos_d  = '0;
          end
        end
        OP_STOP: begin
          if (!running_q) begin
            ctl.status = ST_SAME_STATE;
          end else begin
            running_d = 1'b0;
          end
        end
        OP_SAMPLE: begin
          if (!running_q) begin
            ctl.status = ST_NOT_ACTIVE;
          end else if (stream_id_i >= 8'(StreamCount)) begin
            ctl.status = ST_BAD_STREAM;
          end else begin
            ctl.sample_valid = 1'b1;
            ctl.block_last   = is_last;
            phase_d          = phase_q + step;
            blkpos_d         = is_last ? 16'd0 : blk_next[15:0];
          end
        end
        default: begin
          ctl.status = ST_BAD_STREAM;
        end
      endcase
    end
  end

  // Odd quadrants read the table mirrored, the upper half-turn is negated.
  assign q_ctl_o  = ctl;
  assign q_neg_o  = quad[1];
  assign q_addr_o = quad[0] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, idx})
                            : AddrW'(idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      phase_q   <= '0;
      blkpos_q  <= '0;
    end else if (accept) begin
      running_q <= running_d;
      phase_q   <= phase_d;
      blkpos_q  <= blkpos_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dsss_queue.sv =====
`default_nettype none

module dsss_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);
  import dsss_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dsss_back.sv =====
`default_nettype none

module dsss_back #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Queue read side
  input  wire logic                       q_empty_i,
  output logic                            q_pop_o,
  input  wire dsss_pkg::ctl_t             q_ctl_i,
  input  wire logic                       q_neg_i,
  input  wire logic [TABLE_ADDR_BITS:0]   q_addr_i,
  // Configuration
  input  wire logic signed [15:0]         amplitude_i,
  // Output channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [15:0]              pcm_sample_o,
  output logic                            sample_valid_o,
  output logic                            block_last_o,
  output logic [2:0]                      status_o
);
  import dsss_pkg::*;

  localparam int unsigned TabDepth = (1 << TABLE_ADDR_BITS) + 1;

  typedef logic [SineW-1:0] rom_t [TabDepth];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TabDepth; i++) begin
      r[i] = sine_entry(i, TABLE_ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic             adv;
  logic             s1_vld_q;
  ctl_t             s1_ctl_q;
  logic             s1_neg_q;
  logic [SineW-1:0] rom_q;

  logic             out_vld_q;
  ctl_t             out_ctl_q;
  logic signed [15:0] out_pcm_q;

  logic signed [16:0] sine;
  logic signed [32:0] prod;
  logic signed [32:0] biased;
  logic signed [32:0] scaled;
  logic signed [15:0] pcm_d;

  // The whole back pipeline moves together whenever the output slot frees up.
  assign adv     = !out_vld_q || out_ready_i;
  assign q_pop_o = adv && !q_empty_i;

  // Table read stage.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rom_q    <= SineRom[q_addr_i];
      s1_ctl_q <= q_ctl_i;
      s1_neg_q <= q_neg_i;
    end
  end

  // Scale by the amplitude, divide by 2^15 rounding toward zero.
  assign sine   = s1_neg_q ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});
  assign prod   = sine * amplitude_i;
  assign biased = prod + (prod[32] ? 33'sd32767 : 33'sd0);
  assign scaled = biased >>> 15;
  assign pcm_d  = s1_ctl_q.sample_valid ? scaled[15:0] : 16'sd0;

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      out_ctl_q <= s1_ctl_q;
      out_pcm_q <= pcm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= q_pop_o;
      out_vld_q <= s1_vld_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pcm_sample_o   = out_pcm_q;
  assign sample_valid_o = out_ctl_q.sample_valid;
  assign block_last_o   = out_ctl_q.block_last;
  assign status_o       = out_ctl_q.status;

endmodule

`default_nettype wire

// ===== tb/dds_sine_sample_source_test.sv =====
`default_nettype none

// Self-checking bench for the sine sample source. Commands go in on one
// valid/ready channel and every command returns exactly one result on the
// other. A scoreboard object keeps its own copy of the registers, the phase
// accumulator, the run flag and the block counter. It predicts each result
// when its command transaction is accepted. It then checks the results in
// order as they leave the block.
module dds_sine_sample_source_test;
  import dsss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TabBits    = 10;
  localparam int TabSize    = 1 << TabBits;
  localparam int ItemsPerRun = 160;
  localparam int RunCount   = 12;
  localparam int QuietLimit = 500;

  // One expected result, laid out like the output ports.
  typedef struct packed {
    logic signed [15:0] pcm;
    logic               pcm_ok;
    logic               last;
    status_e            status;
  } tone_result_t;

  // Scoreboard: a predictor of the synthesizer plus the queue of results
  // that are still owed by the block.
  class tone_model;
    logic [31:0]        step;
    logic signed [15:0] amplitude;
    logic [15:0]        block_len;
    logic               configured;
    logic [31:0]        phase;
    logic               active;
    int unsigned        block_pos;
    int                 quarter_wave [0:TabSize];
    tone_result_t       expected_results [$];
    int                 mismatches;

    function new();
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned series;
      longint unsigned scaled;
      longint unsigned taylor_div [5];
      taylor_div = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      // Quarter-wave table in Q1.15: a nested Taylor series for sin(x),
      // evaluated in Q30 with x = (pi/2) * i / 2^TabBits.
      for (longint unsigned i = 0; i <= TabSize; i++) begin
        ang    = (64'd1686629713 * i) >> TabBits;
        ang_sq = (ang * ang) >> 30;
        series = 64'd1 << 30;
        foreach (taylor_div[k]) begin
          series = (64'd1 << 30) - (((ang_sq * series) >> 30) / taylor_div[k]);
        end
        scaled = (ang * series) >> 30;
        scaled = (scaled * 64'd32767 + (64'd1 << 29)) >> 30;
        quarter_wave[i] = (scaled > 64'd32767) ? 32767 : int'(scaled);
      end
      step       = '0;
      amplitude  = 16'sd16384;
      block_len  = 16'd1;
      configured = 1'b0;
      phase      = '0;
      active     = 1'b0;
      block_pos  = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_e idx, logic [31:0] data);
      case (idx)
        REG_PHASE_STEP: step       = data;
        REG_AMPLITUDE:  amplitude  = data[15:0];
        REG_BLOCK_LEN:  block_len  = data[15:0];
        REG_CONFIGURED: configured = data[0];
        default: ;
      endcase
    endfunction

    function int sine_at(logic [31:0] ph);
      int          mag;
      int unsigned idx;
      idx = ph[29:30-TabBits];
      // Odd quadrants run the table backward, the upper half is negated.
      mag = ph[30] ? quarter_wave[TabSize - idx] : quarter_wave[idx];
      return ph[31] ? -mag : mag;
    endfunction

    function void note_command(op_e op, logic [7:0] stream);
      tone_result_t res;
      int           product;
      int unsigned  eff_len;
      res = '{pcm: '0, pcm_ok: 1'b0, last: 1'b0, status: ST_OK};
      if (!configured) begin
        res.status = ST_NOT_CFG;
      end else begin
        case (op)
          OP_START: begin
            if (active) begin
              res.status = ST_SAME_STATE;
            end else begin
              active    = 1'b1;
              phase     = '0;
              block_pos = 0;
            end
          end
          OP_STOP: begin
            if (!active) begin
              res.status = ST_SAME_STATE;
            end else begin
              active = 1'b0;
            end
          end
          OP_SAMPLE: begin
            if (!active) begin
              res.status = ST_NOT_ACTIVE;
            end else if (stream >= StreamCount) begin
              res.status = ST_BAD_STREAM;
            end else begin
              // Signed division truncates toward zero, as the block does.
              product    = sine_at(phase) * int'(amplitude);
              res.pcm    = 16'(product / 32768);
              res.pcm_ok = 1'b1;
              phase      = phase + step;
              eff_len    = (block_len == 16'd0) ? 1 : block_len;
              if (block_pos + 1 >= eff_len) begin
                res.last  = 1'b1;
                block_pos = 0;
              end else begin
                block_pos = (block_pos + 1) & 16'hFFFF;
              end
            end
          end
          default: res.status = ST_BAD_STREAM;
        endcase
      end
      expected_results.push_back(res);
    endfunction

    function void compare_output(logic signed [15:0] pcm, logic pcm_ok, logic last,
                                 logic [2:0] status);
      tone_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: pcm_sample %0d status %0d", pcm, status);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (pcm !== want.pcm) begin
        $error("pcm_sample: expected %0d, got %0d", want.pcm, pcm);
        mismatches++;
      end
      if (pcm_ok !== want.pcm_ok) begin
        $error("sample_valid: expected %0d, got %0d", want.pcm_ok, pcm_ok);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("block_last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = '0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [1:0]         opcode_i    = '0;
  logic [7:0]         stream_id_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] pcm_sample_o;
  logic               sample_valid_o;
  logic               block_last_o;
  logic [2:0]         status_o;

  // Per-run switches for random gaps on the command side and random
  // back-pressure on the result side. When off, that side never idles.
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;

  tone_model model;

  always #5ns clk_i = ~clk_i;

  dds_sine_sample_source u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .stream_id_i    (stream_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pcm_sample_o   (pcm_sample_o),
    .sample_valid_o (sample_valid_o),
    .block_last_o   (block_last_o),
    .status_o       (status_o)
  );

  // Presents one command after a random gap and holds it until the block
  // takes it. Valid is only dropped when a gap follows, so back-to-back
  // commands keep valid high across the edge that accepts the first one.
  // Ready is looked at right after the edge, before the block's registers
  // move, so it is the value that decided the transaction.
  task automatic send_command(op_e op, logic [7:0] stream);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    stream_id_i <= stream;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model.note_command(op, stream);
  endtask

  // Stops sending and waits until every owed result has come back, then
  // lets the two-stage pipeline go quiet.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (model.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all four registers in turn. Unused upper bits of
  // the write data carry noise, since the block must ignore them.
  task automatic program_tone(logic [31:0] step, logic [15:0] amp, logic [15:0] len,
                              logic enable);
    logic [31:0] noise;
    noise = $urandom;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_PHASE_STEP;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    model.write_reg(REG_PHASE_STEP, step);
    cfg_idx_i   <= REG_AMPLITUDE;
    cfg_wdata_i <= {noise[31:16], amp};
    @(posedge clk_i);
    model.write_reg(REG_AMPLITUDE, {noise[31:16], amp});
    cfg_idx_i   <= REG_BLOCK_LEN;
    cfg_wdata_i <= {noise[15:0], len};
    @(posedge clk_i);
    model.write_reg(REG_BLOCK_LEN, {noise[15:0], len});
    cfg_idx_i   <= REG_CONFIGURED;
    cfg_wdata_i <= {noise[31:1], enable};
    @(posedge clk_i);
    model.write_reg(REG_CONFIGURED, {noise[31:1], enable});
    cfg_we_i <= 1'b0;
  endtask

  // Result side: a random stall before each result, then it takes whatever
  // the block offers. Outputs are sampled right after the accepting edge.
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      model.compare_output(pcm_sample_o, sample_valid_o, block_last_o, status_o);
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] step;
    logic [15:0] amp;
    logic [15:0] len;
    logic        enable;
    int          pick;
    model = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Straight out of reset the block is not configured, so every opcode,
    // the unused one too, answers not-configured and changes nothing.
    send_command(OP_START, 8'd0);
    send_command(OP_STOP, 8'd0);
    send_command(OP_SAMPLE, 8'hFF);
    send_command(OP_RSVD, 8'd0);
    drain_results();

    // A quarter-turn step lands exactly on the quadrant boundaries, so the
    // table is read at both of its ends. Blocks of three samples.
    program_tone(32'h4000_0000, 16'h7FFF, 16'd3, 1'b1);
    send_command(OP_STOP, 8'd0);       // already idle
    send_command(OP_SAMPLE, 8'd0);     // not running
    send_command(OP_START, 8'd0);
    send_command(OP_START, 8'd0);      // already running
    repeat (5) send_command(OP_SAMPLE, 8'd0);
    send_command(OP_SAMPLE, 8'd1);     // bad stream
    send_command(OP_SAMPLE, 8'hFF);
    send_command(OP_RSVD, 8'hFF);      // unused opcode
    send_command(OP_STOP, 8'd0);
    send_command(OP_SAMPLE, 8'hFF);    // not running wins over bad stream
    send_command(OP_STOP, 8'd0);
    drain_results();

    // Most negative amplitude, the largest step and a block length of zero,
    // which behaves as one: every sample closes its block.
    program_tone(32'hFFFF_FFFF, 16'h8000, 16'd0, 1'b1);
    send_command(OP_START, 8'd0);
    repeat (3) send_command(OP_SAMPLE, 8'd0);

    // Random runs, each under its own settings. The first few pin the
    // register extremes; one run leaves the block unconfigured.
    for (int run = 0; run < RunCount; run++) begin
      drain_results();
      case (run)
        0: begin
          step = $urandom;
          amp  = 16'h7FFF;
          len  = 16'($urandom_range(1, 6));
        end
        1: begin
          step = 32'h0000_0000;
          amp  = 16'h8000;
          len  = 16'hFFFF;
        end
        2: begin
          step = 32'hFFFF_FFFF;
          amp  = 16'h0000;
          len  = 16'h0000;
        end
        3: begin
          step = 32'h8000_0000;
          amp  = 16'hFFFF;
          len  = 16'd1;
        end
        default: begin
          // Half the runs use slow tones so that neighboring table entries
          // are visited one after another.
          step = $urandom_range(0, 1) ? $urandom : ($urandom >> $urandom_range(8, 24));
          amp  = 16'($urandom);
          len  = 16'($urandom_range(1, 12));
        end
      endcase
      enable = (run != 6);
      program_tone(step, amp, len, enable);

      // One run with no idling anywhere, then one per side, then random.
      case (run)
        0: begin
          tx_gaps_on   = 1'b0;
          rx_stalls_on = 1'b0;
        end
        1: begin
          tx_gaps_on   = 1'b1;
          rx_stalls_on = 1'b0;
        end
        2: begin
          tx_gaps_on   = 1'b0;
          rx_stalls_on = 1'b1;
        end
        default: begin
          tx_gaps_on   = ($urandom_range(0, 3) != 0);
          rx_stalls_on = ($urandom_range(0, 3) != 0);
        end
      endcase

      // Mostly good sample requests on a running block; an idle block is
      // usually started right away, and the rest is stops, restarts, bad
      // streams and the unused opcode.
      for (int n = 0; n < ItemsPerRun; n++) begin
        pick = $urandom_range(0, 99);
        if (!model.active && pick < 50) begin
          send_command(OP_START, 8'($urandom));
        end else if (pick < 76) begin
          send_command(OP_SAMPLE, 8'd0);
        end else if (pick < 81) begin
          send_command(OP_SAMPLE, 8'($urandom_range(1, 255)));
        end else if (pick < 88) begin
          send_command(OP_START, 8'($urandom));
        end else if (pick < 96) begin
          send_command(OP_STOP, 8'($urandom));
        end else begin
          send_command(OP_RSVD, 8'($urandom));
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (model.expected_results.size() != 0) begin
      $error("%0d results never arrived", model.expected_results.size());
    end
    if (model.mismatches == 0 && model.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== dds_sine_sample_source.f =====
hdl/dsss_pkg.sv
hdl/dsss_front.sv
hdl/dsss_queue.sv
hdl/dsss_back.sv
hdl/dds_sine_sample_source.sv
tb/dds_sine_sample_source_test.sv
